// ===== hw/rtl/swfpf_pkg.sv =====
// Shared types, constants and the Q1.15 rounding helper for the sliding-window FFT peak finder.
// Used by swfpf_ctrl, swfpf_dp and sliding_window_fft_peak_finder; depends on nothing.
`default_nettype none

package swfpf_pkg;

   localparam int DEF_WINDOW_POINTS = 256;
   localparam int DEF_SAMPLE_BITS   = 16;
   localparam int SAMPLE_W          = 16;
   localparam int BIN_W             = 7;
   localparam int MAG_W             = 24;
   localparam int COEF_W            = 17;

   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   localparam longint TRIG_ONE  = 64'sd1 << 30;
   localparam longint PI_Q30    = 64'sd3373259426;
   localparam longint HAM_A_Q30 = 64'sd579820585;
   localparam longint HAM_B_Q30 = 64'sd493921239;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD,
      OP_BF_RD,
      OP_BF_SUB,
      OP_BF_MUL,
      OP_BF_WRQ,
      OP_SC_RD,
      OP_SC_ABS,
      OP_SQ_LO,
      OP_SQ_MID,
      OP_SQ_HI,
      OP_RT_INIT,
      OP_RT_STEP,
      OP_CMP,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      busy;
   } dp_cmd_type;

   typedef struct packed {
      logic load_last;
      logic bf_last;
      logic stage_last;
      logic bin_last;
      logic root_last;
      logic out_free;
   } dp_status_type;

   // 30 fraction bits to Q1.15, round half up, clamp to +-1.0
   function automatic int to_q15(input longint v);
      longint r;
      r = ((v + (64'sd1 << 31) + (64'sd1 << 14)) >>> 15) - (64'sd1 << 16);
      if (r > 64'sd32768) r = 64'sd32768;
      if (r < -64'sd32768) r = -64'sd32768;
      return int'(r);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swfpf_ctrl.sv =====
// Sequencer for the peak finder: walks load, FFT butterflies, bin scan and result hand-off.
// Depends on swfpf_pkg; drives swfpf_dp through dp_cmd_type and reads dp_status_type.
`default_nettype none

module swfpf_ctrl
   import swfpf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_BF_RD,
      ST_BF_SUB,
      ST_BF_MUL,
      ST_BF_WRQ,
      ST_SC_RD,
      ST_SC_ABS,
      ST_SQ_LO,
      ST_SQ_MID,
      ST_SQ_HI,
      ST_RT_INIT,
      ST_RT_STEP,
      ST_CMP,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      cmd.busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op = OP_LOAD;
            if (status.load_last) state_in = ST_BF_RD;
         end
         ST_BF_RD: begin
            cmd.op   = OP_BF_RD;
            state_in = ST_BF_SUB;
         end
         ST_BF_SUB: begin
            cmd.op   = OP_BF_SUB;
            state_in = ST_BF_MUL;
         end
         ST_BF_MUL: begin
            cmd.op   = OP_BF_MUL;
            state_in = ST_BF_WRQ;
         end
         ST_BF_WRQ: begin
            cmd.op   = OP_BF_WRQ;
            state_in = (status.bf_last && status.stage_last) ? ST_SC_RD : ST_BF_RD;
         end
         ST_SC_RD: begin
            cmd.op   = OP_SC_RD;
            state_in = ST_SC_ABS;
         end
         ST_SC_ABS: begin
            cmd.op   = OP_SC_ABS;
            state_in = ST_SQ_LO;
         end
         ST_SQ_LO: begin
            cmd.op   = OP_SQ_LO;
            state_in = ST_SQ_MID;
         end
         ST_SQ_MID: begin
            cmd.op   = OP_SQ_MID;
            state_in = ST_SQ_HI;
         end
         ST_SQ_HI: begin
            cmd.op   = OP_SQ_HI;
            state_in = ST_RT_INIT;
         end
         ST_RT_INIT: begin
            cmd.op   = OP_RT_INIT;
            state_in = ST_RT_STEP;
         end
         ST_RT_STEP: begin
            cmd.op = OP_RT_STEP;
            if (status.root_last) state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.op   = OP_CMP;
            state_in = status.bin_last ? ST_OUT : ST_SC_RD;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/swfpf_dp.sv =====
// Datapath: sample ring buffer, Hamming load, in-place radix-2 DIF FFT, magnitude scan
// and result register. Depends on swfpf_pkg; sequenced by swfpf_ctrl.
`default_nettype none

module swfpf_dp
   import swfpf_pkg::*;
#(
   parameter int WINDOW_POINTS = DEF_WINDOW_POINTS,
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
)(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [BIN_W-1:0]           rsp_peak_bin,
   output logic [MAG_W-1:0]           rsp_peak_magnitude
);

   localparam int LOG2N = $clog2(WINDOW_POINTS);
   localparam int HALF  = WINDOW_POINTS / 2;
   localparam int AW    = LOG2N;
   localparam int BW    = LOG2N - 1;
   localparam int SGW   = $clog2(LOG2N);
   localparam int DW    = SAMPLE_BITS + LOG2N + 16;   // no-scaling FFT word
   localparam int RW    = DW - 15;                    // root width
   localparam int HW    = (DW + 1) / 2;               // square split
   localparam int SW    = 2 * DW;
   localparam int TW    = 2 * RW;
   localparam int RSW   = $clog2(RW);
   localparam int XW    = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int MW    = (RW > MAG_W) ? RW : MAG_W;
   localparam int PW    = DW + 16;

   // angle denominators: N-1 for the window, N for the twiddles
   localparam longint TW_DEN   = longint'(WINDOW_POINTS);
   localparam longint WIN_DEN  = longint'(WINDOW_POINTS - 1);
   localparam longint TW_DEN2  = 2 * TW_DEN;
   localparam longint WIN_DEN2 = 2 * WIN_DEN;

   // cos or sin of 2*pi*num/den with 30 fraction bits (Taylor series after range reduction)
   function automatic longint trig_q30(input longint num, input bit for_win,
                                       input bit want_sin);
      longint den, q, r, x, x2, sn, cs, t, c, s;
      den = for_win ? WIN_DEN : TW_DEN;
      q   = for_win ? (8 * num + WIN_DEN) / WIN_DEN2 : (8 * num + TW_DEN) / TW_DEN2;
      r   = 4 * num - q * den;
      x   = for_win ? PI_Q30 * r / WIN_DEN2 : PI_Q30 * r / TW_DEN2;
      x2  = x * x / TRIG_ONE;
      // sine terms, divisors (2i)(2i+1)
      sn = x;
      t  = x;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd6);    sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd20);   sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd42);   sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd72);   sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd110);  sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd156);  sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd210);  sn += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd272);  sn += t;
      // cosine terms, divisors (2i-1)(2i)
      cs = TRIG_ONE;
      t  = TRIG_ONE;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd2);    cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd12);   cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd30);   cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd56);   cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd90);   cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd132);  cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd182);  cs += t;
      t = t * x2 / TRIG_ONE;  t = -(t / 64'sd240);  cs += t;
      if (q[1:0] == 2'd0) begin
         c = cs;  s = sn;
      end else if (q[1:0] == 2'd1) begin
         c = -sn; s = cs;
      end else if (q[1:0] == 2'd2) begin
         c = -cs; s = -sn;
      end else begin
         c = sn;  s = -cs;
      end
      return want_sin ? s : c;
   endfunction

   function automatic int win_coef_q15(input int k);
      return to_q15(HAM_A_Q30 - HAM_B_Q30 * trig_q30(longint'(k), 1'b1, 1'b0) / TRIG_ONE);
   endfunction

   function automatic int twiddle_q15(input int m, input bit want_sin);
      return to_q15(trig_q30(longint'(m), 1'b0, want_sin));
   endfunction

   // ---------------- control registers
   logic [AW-1:0]  wp_ff, cnt_ff;
   logic [AW:0]    fill_ff;
   logic [SGW-1:0] stage_ff;
   logic [RSW-1:0] rstep_ff;
   logic           ld_wen_ff;
   logic           rsp_valid_ff;

   // ---------------- payload
   logic [SAMPLE_BITS-1:0]        win_mem [WINDOW_POINTS];
   logic signed [SAMPLE_BITS-1:0] win_rd_ff;
   logic signed [COEF_W-1:0]      coef_rom [WINDOW_POINTS];
   logic signed [COEF_W-1:0]      coef_ff;
   logic signed [COEF_W-1:0]      cos_rom [HALF];
   logic signed [COEF_W-1:0]      sin_rom [HALF];
   logic signed [COEF_W-1:0]      cos_ff, sin_ff;
   logic [AW-1:0]                 ld_idx_ff;
   logic                          ld_valid_ff;

   logic [2*DW-1:0]               work_mem [WINDOW_POINTS];
   logic [2*DW-1:0]               rd_a_ff, rd_b_ff;

   logic signed [DW-1:0]          sum_re_ff, sum_im_ff;
   logic [DW-1:0]                 dr_abs_ff, di_abs_ff;
   logic                          dr_neg_ff, di_neg_ff;
   logic [15:0]                   c_abs_ff, s_abs_ff;
   logic                          c_neg_ff, s_neg_ff;
   logic [DW-1:0]                 pr_ff [4];
   logic [3:0]                    pn_ff;

   logic [DW-1:0]                 abs_re_ff, abs_im_ff;
   logic [SW-1:0]                 acc_ff;
   logic [TW-1:0]                 num_ff, res_ff, bit_ff;
   logic [MAG_W-1:0]              best_mag_ff;
   logic [BW-1:0]                 best_bin_ff;
   logic [BIN_W-1:0]              rsp_bin_ff;
   logic [MAG_W-1:0]              rsp_mag_ff;

   // ---------------- constant tables
   for (genvar g = 0; g < WINDOW_POINTS; g++) begin : g_coef
      assign coef_rom[g] = COEF_W'(win_coef_q15(g));
   end
   for (genvar g = 0; g < HALF; g++) begin : g_twid
      assign cos_rom[g] = COEF_W'(twiddle_q15(g, 1'b0));
      assign sin_rom[g] = COEF_W'(twiddle_q15(g, 1'b1));
   end

   // ---------------- input sample, bits above SAMPLE_BITS dropped
   logic [XW-1:0]          sample_ext;
   logic [SAMPLE_BITS-1:0] sample_sb;
   assign sample_ext = XW'($unsigned(sample));
   assign sample_sb  = sample_ext[SAMPLE_BITS-1:0];

   // ---------------- butterfly addressing
   logic [BW-1:0] half_mask, bfly, jj, tw_idx;
   logic [AW-1:0] p_addr, q_addr, scan_addr, ra;
   logic [AW:0]   ld_pos;

   always_comb begin
      half_mask = BW'(HALF - 1) >> stage_ff;
      bfly      = cnt_ff[BW-1:0];
      jj        = bfly & half_mask;
      p_addr    = {bfly & ~half_mask, 1'b0} | {1'b0, jj};
      q_addr    = p_addr | (AW'(HALF) >> stage_ff);
      tw_idx    = jj << stage_ff;
      for (int b = 0; b < AW; b++) begin
         scan_addr[b] = cnt_ff[AW-1-b];
      end
      ra     = (cmd.op == OP_BF_RD) ? p_addr : scan_addr;
      ld_pos = {1'b0, cnt_ff} + fill_ff;
   end

   // ---------------- arithmetic
   logic signed [SAMPLE_BITS+COEF_W-1:0] ld_prod;
   logic signed [DW-1:0]                 ld_re;
   logic signed [DW-1:0]                 a_re, a_im, b_re, b_im, dr, di;
   logic [PW-1:0]                        mp [4];
   logic [PW-1:0]                        mr [4];
   logic signed [DW-1:0]                 sp [4];
   logic signed [DW-1:0]                 q_re, q_im;
   logic [HW-1:0]                        m_re1, m_re2, m_im1, m_im2;
   logic [2*HW-1:0]                      prod_re, prod_im;
   logic [SW-1:0]                        acc_in;
   int unsigned                          sq_sh;
   logic [TW:0]                          trial;
   logic [RW-1:0]                        root;
   logic [MW-1:0]                        root_ext;
   logic [MAG_W-1:0]                     mag;

   always_comb begin
      ld_prod = win_rd_ff * coef_ff;
      ld_re   = ld_valid_ff ? DW'(ld_prod) : '0;

      a_re = signed'(rd_a_ff[2*DW-1:DW]);
      a_im = signed'(rd_a_ff[DW-1:0]);
      b_re = signed'(rd_b_ff[2*DW-1:DW]);
      b_im = signed'(rd_b_ff[DW-1:0]);
      dr   = a_re - b_re;
      di   = a_im - b_im;

      // |v|*|c|, rounded half away from zero after sign is applied
      mp[0] = PW'(dr_abs_ff) * PW'(c_abs_ff);
      mp[1] = PW'(di_abs_ff) * PW'(s_abs_ff);
      mp[2] = PW'(di_abs_ff) * PW'(c_abs_ff);
      mp[3] = PW'(dr_abs_ff) * PW'(s_abs_ff);
      for (int i = 0; i < 4; i++) begin
         mr[i] = mp[i] + PW'(16384);
         sp[i] = pn_ff[i] ? -signed'(pr_ff[i]) : signed'(pr_ff[i]);
      end
      q_re = sp[0] + sp[1];
      q_im = sp[2] - sp[3];

      // squares in three partial-product passes
      case (cmd.op)
         OP_SQ_MID: begin
            m_re1 = HW'(abs_re_ff >> HW);
            m_re2 = abs_re_ff[HW-1:0];
            m_im1 = HW'(abs_im_ff >> HW);
            m_im2 = abs_im_ff[HW-1:0];
            sq_sh = HW + 1;
         end
         OP_SQ_HI: begin
            m_re1 = HW'(abs_re_ff >> HW);
            m_re2 = HW'(abs_re_ff >> HW);
            m_im1 = HW'(abs_im_ff >> HW);
            m_im2 = HW'(abs_im_ff >> HW);
            sq_sh = 2 * HW;
         end
         default: begin
            m_re1 = abs_re_ff[HW-1:0];
            m_re2 = abs_re_ff[HW-1:0];
            m_im1 = abs_im_ff[HW-1:0];
            m_im2 = abs_im_ff[HW-1:0];
            sq_sh = 0;
         end
      endcase
      prod_re = m_re1 * m_re2;
      prod_im = m_im1 * m_im2;
      acc_in  = acc_ff + (SW'(prod_re) << sq_sh) + (SW'(prod_im) << sq_sh);

      trial    = {1'b0, res_ff} + {1'b0, bit_ff};
      root     = res_ff[RW-1:0];
      root_ext = MW'(root);
      mag      = (root_ext > MW'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
   end

   // ---------------- status
   always_comb begin
      status.load_last  = (cnt_ff == AW'(WINDOW_POINTS - 1));
      status.bf_last    = &bfly;
      status.stage_last = (stage_ff == SGW'(LOG2N - 1));
      status.bin_last   = (cnt_ff == AW'(HALF - 1));
      status.root_last  = (rstep_ff == RSW'(RW - 1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // ---------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         stage_ff     <= '0;
         rstep_ff     <= '0;
         ld_wen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ld_wen_ff    <= (cmd.op == OP_LOAD);
         // held until the transfer, set again by a new result
         rsp_valid_ff <= (cmd.op == OP_OUT) || (rsp_valid_ff && rsp_stall);
         case (cmd.op)
            OP_ACCEPT: begin
               wp_ff    <= wp_ff + AW'(1);
               cnt_ff   <= '0;
               stage_ff <= '0;
               if (fill_ff != (AW+1)'(WINDOW_POINTS)) fill_ff <= fill_ff + (AW+1)'(1);
            end
            OP_LOAD:    cnt_ff <= cnt_ff + AW'(1);
            OP_BF_WRQ: begin
               if (status.bf_last) begin
                  stage_ff <= stage_ff + SGW'(1);
                  // bin scan starts at bin 1
                  cnt_ff   <= status.stage_last ? AW'(1) : '0;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            OP_RT_INIT: rstep_ff <= '0;
            OP_RT_STEP: rstep_ff <= rstep_ff + RSW'(1);
            OP_CMP:     cnt_ff <= cnt_ff + AW'(1);
            default: ;
         endcase
      end
   end

   // ---------------- memories and data registers
   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) win_mem[wp_ff] <= sample_sb;
      win_rd_ff   <= signed'(win_mem[wp_ff + cnt_ff]);
      coef_ff     <= coef_rom[cnt_ff];
      ld_idx_ff   <= cnt_ff;
      ld_valid_ff <= (ld_pos >= (AW+1)'(WINDOW_POINTS));
      cos_ff      <= cos_rom[tw_idx];
      sin_ff      <= sin_rom[tw_idx];

      if (ld_wen_ff) begin
         work_mem[ld_idx_ff] <= {ld_re, {DW{1'b0}}};
      end else if (cmd.op == OP_BF_MUL) begin
         work_mem[p_addr] <= {sum_re_ff, sum_im_ff};
      end else if (cmd.op == OP_BF_WRQ) begin
         work_mem[q_addr] <= {q_re, q_im};
      end
      rd_a_ff <= work_mem[ra];
      rd_b_ff <= work_mem[q_addr];

      if (cmd.op == OP_BF_SUB) begin
         sum_re_ff <= a_re + b_re;
         sum_im_ff <= a_im + b_im;
         dr_neg_ff <= dr[DW-1];
         di_neg_ff <= di[DW-1];
         dr_abs_ff <= dr[DW-1] ? DW'(-dr) : DW'(dr);
         di_abs_ff <= di[DW-1] ? DW'(-di) : DW'(di);
         c_neg_ff  <= cos_ff[COEF_W-1];
         s_neg_ff  <= sin_ff[COEF_W-1];
         c_abs_ff  <= cos_ff[COEF_W-1] ? 16'(-cos_ff) : 16'(cos_ff);
         s_abs_ff  <= sin_ff[COEF_W-1] ? 16'(-sin_ff) : 16'(sin_ff);
      end
      if (cmd.op == OP_BF_MUL) begin
         for (int i = 0; i < 4; i++) begin
            pr_ff[i] <= mr[i][DW+14:15];
         end
         pn_ff <= {dr_neg_ff ^ s_neg_ff, di_neg_ff ^ c_neg_ff,
                   di_neg_ff ^ s_neg_ff, dr_neg_ff ^ c_neg_ff};
      end

      if (cmd.op == OP_SC_ABS) begin
         abs_re_ff <= a_re[DW-1] ? DW'(-a_re) : DW'(a_re);
         abs_im_ff <= a_im[DW-1] ? DW'(-a_im) : DW'(a_im);
         acc_ff    <= '0;
      end
      if (cmd.op == OP_SQ_LO || cmd.op == OP_SQ_MID || cmd.op == OP_SQ_HI) acc_ff <= acc_in;

      // floor(sqrt(S / 2^30)) equals floor(sqrt(S)) >> 15
      if (cmd.op == OP_RT_INIT) begin
         num_ff <= acc_ff[SW-1:30];
         res_ff <= '0;
         bit_ff <= TW'(1) << (TW - 2);
      end
      if (cmd.op == OP_RT_STEP) begin
         if ({1'b0, num_ff} >= trial) begin
            num_ff <= num_ff - trial[TW-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      if (cmd.op == OP_ACCEPT) begin
         best_mag_ff <= '0;
         best_bin_ff <= '0;
      end
      if (cmd.op == OP_CMP && mag > best_mag_ff) begin
         best_mag_ff <= mag;
         best_bin_ff <= cnt_ff[BW-1:0];
      end
      if (cmd.op == OP_OUT) begin
         rsp_bin_ff <= BIN_W'(best_bin_ff);
         rsp_mag_ff <= best_mag_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peak_bin       = rsp_bin_ff;
   assign rsp_peak_magnitude = rsp_mag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_fft_peak_finder.sv =====
// Sliding-window FFT peak finder, top level.
// Depends on swfpf_pkg, swfpf_ctrl and swfpf_dp.
//
// Input channel req_*: one signed sample per transfer, shifted into a ring buffer
// holding the newest WINDOW_POINTS samples. Each sample triggers a Hamming-windowed
// N-point radix-2 FFT (no scaling) and a scan of bins 1..N/2-1.
// Result channel rsp_*: one transfer per sample with the first bin of largest
// floored magnitude and that magnitude (bin 0, magnitude 0 when all bins are zero).
// N = WINDOW_POINTS. Each butterfly steps through read, add and subtract, twiddle
// multiply and write-back on the single-write work memory, and the scan takes one
// root bit per cycle in a shared square-root unit.
// One sample is processed at a time; req_stall is high from accept until the
// result is loaded into the output register. The next sample is taken while that
// result waits under rsp_stall; a finished result waits only if the register is full.
// Reset clears the window (a fill count marks unwritten entries as zero) and
// drops any pending result; no clearing pass is needed.
`default_nettype none

module sliding_window_fft_peak_finder
   import swfpf_pkg::*;
#(
   parameter int WINDOW_POINTS = DEF_WINDOW_POINTS,
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [BIN_W-1:0]           rsp_peak_bin,
   output logic [MAG_W-1:0]           rsp_peak_magnitude
);

   dp_cmd_type    cmd;
   dp_status_type status;

   swfpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   swfpf_dp #(
      .WINDOW_POINTS (WINDOW_POINTS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .sample             (req_sample),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_peak_bin       (rsp_peak_bin),
      .rsp_peak_magnitude (rsp_peak_magnitude)
   );

   assign req_stall = cmd.busy;

endmodule

`default_nettype wire

// ===== tb/tb_sliding_window_fft_peak_finder.sv =====
// Self-checking testbench for sliding_window_fft_peak_finder: drives samples, predicts the
// peak bin and magnitude with an in-bench windowed FFT and compares every result transfer.
// Depends on swfpf_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_sliding_window_fft_peak_finder;
   import swfpf_pkg::*;

   localparam int NPTS = 256;
   localparam int HALF = NPTS / 2;
   localparam int LATENCY = 8418;
   localparam int LONG_HOLD = 30000;

   typedef struct {
      logic [BIN_W-1:0] bin;
      logic [MAG_W-1:0] mag;
   } peak_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [BIN_W-1:0]           rsp_peak_bin;
   logic [MAG_W-1:0]           rsp_peak_magnitude;

   peak_type peak_queue[$];
   longint   history[NPTS];
   longint   ham_coef[NPTS];
   longint   tw_re[HALF];
   longint   tw_im[HALF];
   int       errors = 0;
   int       send_gap_max = 0;
   int       recv_gap_max = 0;
   int       hold_req = 0;
   int       hold_seen = 0;
   int       hold_left = 0;
   int       recv_left = 0;

   sliding_window_fft_peak_finder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_peak_bin       (rsp_peak_bin),
      .rsp_peak_magnitude (rsp_peak_magnitude)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // cos/sin of 2*pi*num/den with 30 fraction bits, octant reduction then Taylor series
   function automatic void trig30(input longint num, input longint den,
                                  output longint c, output longint s);
      longint q, r, x, x2, sn, cs, t;
      q = (8 * num + den) / (2 * den);
      r = 4 * num - q * den;
      x = PI_Q30 * r / (2 * den);
      x2 = x * x / TRIG_ONE;
      sn = x;
      cs = TRIG_ONE;
      t = x;
      for (int i = 1; i <= 8; i++) begin
         t = t * x2 / TRIG_ONE;
         t = -(t / longint'((2 * i) * (2 * i + 1)));
         sn += t;
      end
      t = TRIG_ONE;
      for (int i = 1; i <= 8; i++) begin
         t = t * x2 / TRIG_ONE;
         t = -(t / longint'((2 * i - 1) * (2 * i)));
         cs += t;
      end
      case (q & 3)
         0: begin c = cs;  s = sn;  end
         1: begin c = -sn; s = cs;  end
         2: begin c = -cs; s = -sn; end
         default: begin c = sn; s = -cs; end
      endcase
   endfunction

   function automatic longint round_q15(input longint v);
      longint r;
      r = ((v + (64'sd1 << 31) + (64'sd1 << 14)) >>> 15) - (64'sd1 << 16);
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic void build_coefs();
      longint c, s;
      for (int k = 0; k < NPTS; k++) begin
         trig30(k, NPTS - 1, c, s);
         ham_coef[k] = round_q15(HAM_A_Q30 - HAM_B_Q30 * c / TRIG_ONE);
      end
      for (int k = 0; k < HALF; k++) begin
         trig30(k, NPTS, c, s);
         tw_re[k] = round_q15(c);
         tw_im[k] = round_q15(s);
      end
   endfunction

   // v * c / 2^15, ties away from zero
   function automatic longint twiddle_mul(input longint v, input longint c);
      bit neg;
      longint unsigned a, b, p;
      neg = (v < 0) != (c < 0);
      a = v < 0 ? -v : v;
      b = c < 0 ? -c : c;
      p = (a >> 15) * b + (((a & 64'h7FFF) * b + 64'h4000) >> 15);
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [MAG_W-1:0] bin_magnitude(input longint re, input longint im);
      logic [127:0] a, b, n, root, cand;
      a = re < 0 ? 128'(-re) : 128'(re);
      b = im < 0 ? 128'(-im) : 128'(im);
      n = a * a + b * b;
      root = '0;
      for (int bt = 62; bt >= 0; bt--) begin
         cand = root | (128'd1 << bt);
         if (cand * cand <= n) root = cand;
      end
      root = root >> 15;
      return root > 128'(MAG_MAX) ? MAG_MAX : root[MAG_W-1:0];
   endfunction

   // shift the sample in, window, transform and pick the strongest non-DC bin
   function automatic peak_type spectral_peak(input longint smp);
      longint re[NPTS], im[NPTS];
      longint dr, di, tr, ti, c, s;
      logic [MAG_W-1:0] m;
      peak_type pk;
      int h, stride, rev;
      for (int k = 0; k < NPTS - 1; k++) history[k] = history[k + 1];
      history[NPTS - 1] = smp;
      for (int k = 0; k < NPTS; k++) begin
         re[k] = history[k] * ham_coef[k];
         im[k] = 0;
      end
      for (int len = NPTS; len >= 2; len = len / 2) begin
         h = len / 2;
         stride = NPTS / len;
         for (int st = 0; st < NPTS; st += len) begin
            for (int j = 0; j < h; j++) begin
               c = tw_re[(j * stride) % HALF];
               s = tw_im[(j * stride) % HALF];
               dr = re[st + j] - re[st + j + h];
               di = im[st + j] - im[st + j + h];
               re[st + j] += re[st + j + h];
               im[st + j] += im[st + j + h];
               re[st + j + h] = twiddle_mul(dr, c) + twiddle_mul(di, s);
               im[st + j + h] = twiddle_mul(di, c) - twiddle_mul(dr, s);
            end
         end
      end
      for (int k = 0; k < NPTS; k++) begin
         rev = 0;
         for (int b = 0; b < 8; b++) rev |= ((k >> b) & 1) << (7 - b);
         if (rev > k) begin
            tr = re[k]; ti = im[k];
            re[k] = re[rev]; im[k] = im[rev];
            re[rev] = tr; im[rev] = ti;
         end
      end
      pk.bin = '0;
      pk.mag = '0;
      for (int k = 1; k < HALF; k++) begin
         m = bin_magnitude(re[k], im[k]);
         if (m > pk.mag) begin
            pk.mag = m;
            pk.bin = BIN_W'(k);
         end
      end
      return pk;
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      peak_queue.push_back(spectral_peak(longint'(smp)));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] tone(input int amp, input int bin, input int n);
      longint c, s;
      trig30((bin * n) % NPTS, NPTS, c, s);
      return SAMPLE_W'((longint'(amp) * c) >>> 30);
   endfunction

   // receiver: random pause after each transfer, plus one long hold-off on request
   always @(posedge clock) begin
      int nxt;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         nxt = recv_left;
         if (rsp_valid && !rsp_stall) nxt = $urandom_range(0, recv_gap_max);
         else if (nxt > 0) nxt--;
         recv_left = nxt;
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (nxt != 0) || (hold_left != 0);
      end
   end

   always @(posedge clock) begin
      peak_type exp_pk;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (peak_queue.size() == 0) begin
            $error("unexpected result transfer: peak_bin %0d peak_magnitude %0d",
                   rsp_peak_bin, rsp_peak_magnitude);
            errors++;
         end else begin
            exp_pk = peak_queue.pop_front();
            if (rsp_peak_bin !== exp_pk.bin) begin
               $error("peak_bin expected %0d actual %0d", exp_pk.bin, rsp_peak_bin);
               errors++;
            end
            if (rsp_peak_magnitude !== exp_pk.mag) begin
               $error("peak_magnitude expected %0d actual %0d", exp_pk.mag, rsp_peak_magnitude);
               errors++;
            end
         end
      end
   end

   // empty window, lone impulse (every bin ties), full-scale extremes
   task automatic test_extremes();
      send_gap_max = 0;
      recv_gap_max = 0;
      send_sample(16'sd0);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      for (int n = 0; n < 6; n++) send_sample(n % 2 ? -16'sd32768 : 16'sd32767);
   endtask

   task automatic test_tones();
      send_gap_max = 19;
      recv_gap_max = 19;
      for (int n = 0; n < 6; n++) send_sample(tone(32767, 127, n));
      for (int n = 0; n < 6; n++) send_sample(tone(20000, 1, n));
   endtask

   task automatic test_backpressure();
      send_gap_max = 0;
      recv_gap_max = 0;
      hold_req = hold_req + 1;
      for (int n = 0; n < 6; n++) send_sample(16'($urandom));
   endtask

   task automatic test_random();
      int kind, amp, bin;
      for (int n = 0; n < 265; n++) begin
         if (n % 40 == 0) begin
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
            recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
            amp = $urandom_range(1, 32767);
            bin = $urandom_range(1, HALF - 1);
         end
         kind = $urandom_range(0, 99);
         if (kind < 40)
            send_sample(tone(amp, bin, n) + 16'($signed($urandom_range(0, 15)) - 8));
         else if (kind < 70)
            send_sample(16'($urandom));
         else if (kind < 85)
            send_sample(16'($signed($urandom_range(0, 8)) - 4));
         else
            send_sample($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      for (int k = 0; k < NPTS; k++) history[k] = 0;
      build_coefs();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_tones();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (peak_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 100) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("simulation failed");
      $finish;
   end

endmodule
